>>> design/dsa_pkg.sv
// Shared types and constants for the DFA string acceptor.
package dsa_pkg;

	localparam int MAX_TRANS_DEF = 64;

	// Default start state and the empty-string symbol ('0' and '-')
	localparam logic [7:0] RESET_START = 8'h30;
	localparam logic [7:0] LAMBDA_SYM  = 8'h2D;

	localparam int MARK_DEPTH = 256;

	// Item action codes
	localparam logic [1:0] ACT_TRANS  = 2'd0;
	localparam logic [1:0] ACT_FINAL  = 2'd1;
	localparam logic [1:0] ACT_ALPHA  = 2'd2;
	localparam logic [1:0] ACT_SYMBOL = 2'd3;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START = 1'd1;

	typedef struct packed {
		logic [7:0] from_state;
		logic [7:0] symbol;
		logic [7:0] to_state;
	} trans_entry_t;

	typedef struct packed {
		logic       wr_final;
		logic       wr_alpha;
		logic [7:0] addr;
		logic       value;
	} mark_wr_t;

endpackage

>>> design/dsa_trans_mem.sv
// Transition list memory: one write port, one registered read port.
module dsa_trans_mem #(
	parameter int DEPTH = dsa_pkg::MAX_TRANS_DEF,
	parameter int IDX_W = 6
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [IDX_W-1:0]      waddr,
	input  dsa_pkg::trans_entry_t wdata,
	input  logic                  re,
	input  logic [IDX_W-1:0]      raddr,
	output dsa_pkg::trans_entry_t rdata
);

	dsa_pkg::trans_entry_t mem [0:DEPTH-1];
	dsa_pkg::trans_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/dsa_mark_mem.sv
// Final and alphabet mark memory with per-bit writes and a clearing sweep after reset.
module dsa_mark_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  dsa_pkg::mark_wr_t wr,
	input  logic              re_a,
	input  logic [7:0]        addr_a,
	input  logic              re_b,
	input  logic [7:0]        addr_b,
	output logic              final_rd,
	output logic              alpha_rd,
	output logic              busy
);

	// bit 1: final mark, bit 0: alphabet mark
	logic [1:0] mem [0:dsa_pkg::MARK_DEPTH-1];
	logic       clr_busy_q;
	logic [7:0] clr_addr_q;
	logic       final_q;
	logic       alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 8'd1;
			if (clr_addr_q == 8'(dsa_pkg::MARK_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= 2'b00;
		end else begin
			if (wr.wr_final) begin
				mem[wr.addr][1] <= wr.value;
			end
			if (wr.wr_alpha) begin
				mem[wr.addr][0] <= wr.value;
			end
		end
		if (re_a) begin
			final_q <= mem[addr_a][1];
		end
		if (re_b) begin
			alpha_q <= mem[addr_b][0];
		end
	end

	assign final_rd = final_q;
	assign alpha_rd = alpha_q;
	assign busy     = clr_busy_q;

endmodule

>>> design/dfa_string_acceptor_core.sv
// DFA string acceptor. Set-up words (transition writes, final and alphabet mark writes) are taken
// while idle and written directly. A string symbol reads its marks, then compares transition entries:
// the list is scanned in order through the single read port of the transition memory, up to the
// active count and at most MAX_TRANSITIONS entries; the last symbol of a string adds the final-state
// lookup and the verdict. After reset the mark memory is swept to zero, during which no word is
// taken (configuration writes still are). The verdict sits in an output register, so the next
// word can be taken while it waits.
module dfa_string_acceptor_core #(
	parameter int MAX_TRANSITIONS = dsa_pkg::MAX_TRANS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    action,
	input  logic [5:0]                    entry_index,
	input  logic [7:0]                    from_state,
	input  logic [7:0]                    symbol,
	input  logic [7:0]                    to_state,
	input  logic                          mark_value,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          accepted,
	input  logic                          cfg_we,
	input  logic [dsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);

	localparam int IDX_W = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
	localparam int CNT_W = $clog2(MAX_TRANSITIONS + 1);
	localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_MARK,
		ST_CHECK,
		ST_SEARCH,
		ST_RD_FINAL,
		ST_DONE
	} state_t;

	state_t             st_q;
	logic [6:0]         count_q;
	logic [7:0]         start_q;
	logic [7:0]         cur_q;
	logic               decided_q;
	logic               verdict_q;
	logic               in_string_q;
	logic [7:0]         sym_q;
	logic               last_q;
	logic [CMP_W-1:0]   issue_q;
	logic               rd_v_s1;
	logic               out_valid_q;
	logic               accepted_q;

	logic               accept;
	logic               clr_busy;
	logic [CMP_W-1:0]   max_ext;
	logic [CMP_W-1:0]   count_ext;
	logic [CMP_W-1:0]   n_act;
	logic               slot_ok;
	logic               dec_eff;
	logic               match;
	logic               issue_en;
	logic               final_rd;
	logic               alpha_rd;
	logic               mark_re_a;
	logic               mark_re_b;
	dsa_pkg::mark_wr_t     mark_wr;
	dsa_pkg::trans_entry_t tl_wdata;
	dsa_pkg::trans_entry_t tl_rdata;

	assign in_stall = (st_q != ST_IDLE) || clr_busy;
	assign accept   = in_valid && !in_stall;

	assign max_ext   = CMP_W'(MAX_TRANSITIONS);
	assign count_ext = CMP_W'(count_q);
	assign n_act     = (count_ext > max_ext) ? max_ext : count_ext;
	assign slot_ok   = CMP_W'(entry_index) < max_ext;
	assign dec_eff   = in_string_q && decided_q;

	assign match = rd_v_s1 && (tl_rdata.symbol == sym_q) && (tl_rdata.from_state == cur_q);
	assign issue_en = (st_q == ST_SEARCH) && (issue_q < n_act) && !match;

	assign tl_wdata.from_state = from_state;
	assign tl_wdata.symbol     = symbol;
	assign tl_wdata.to_state   = to_state;

	assign mark_wr.wr_final = accept && (action == dsa_pkg::ACT_FINAL);
	assign mark_wr.wr_alpha = accept && (action == dsa_pkg::ACT_ALPHA);
	assign mark_wr.addr     = symbol;
	assign mark_wr.value    = mark_value;

	assign mark_re_a = (st_q == ST_RD_MARK) || (st_q == ST_RD_FINAL);
	assign mark_re_b = (st_q == ST_RD_MARK);

	dsa_trans_mem #(
		.DEPTH (MAX_TRANSITIONS),
		.IDX_W (IDX_W)
	) u_trans_mem (
		.clk   (clk),
		.we    (accept && (action == dsa_pkg::ACT_TRANS) && slot_ok),
		.waddr (IDX_W'(entry_index)),
		.wdata (tl_wdata),
		.re    (issue_en),
		.raddr (issue_q[IDX_W-1:0]),
		.rdata (tl_rdata)
	);

	dsa_mark_mem u_mark_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (mark_wr),
		.re_a     (mark_re_a),
		.addr_a   (cur_q),
		.re_b     (mark_re_b),
		.addr_b   (sym_q),
		.final_rd (final_rd),
		.alpha_rd (alpha_rd),
		.busy     (clr_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			start_q <= dsa_pkg::RESET_START;
		end else if (cfg_we) begin
			case (cfg_index)
				dsa_pkg::REG_COUNT: count_q <= cfg_data[6:0];
				dsa_pkg::REG_START: start_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cur_q       <= dsa_pkg::RESET_START;
			decided_q   <= 1'b0;
			verdict_q   <= 1'b0;
			in_string_q <= 1'b0;
			sym_q       <= '0;
			last_q      <= 1'b0;
			issue_q     <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			accepted_q  <= 1'b0;
		end else begin
			rd_v_s1 <= issue_en;
			if (issue_en) begin
				issue_q <= issue_q + CMP_W'(1);
			end
			// ST_DONE reloads the output word itself
			if (out_valid_q && !out_stall && (st_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (accept && (action == dsa_pkg::ACT_SYMBOL)) begin
						sym_q       <= symbol;
						last_q      <= last;
						in_string_q <= 1'b1;
						if (!in_string_q) begin
							cur_q     <= start_q;
							decided_q <= 1'b0;
							verdict_q <= 1'b0;
						end
						if (!dec_eff) begin
							st_q <= ST_RD_MARK;
						end else if (last) begin
							st_q <= ST_RD_FINAL;
						end
					end
				end
				ST_RD_MARK: begin
					st_q <= ST_CHECK;
				end
				ST_CHECK: begin
					issue_q <= '0;
					if (n_act == '0) begin
						decided_q <= 1'b1;
						verdict_q <= 1'b0;
						st_q      <= last_q ? ST_RD_FINAL : ST_IDLE;
					end else if ((sym_q == dsa_pkg::LAMBDA_SYM) && final_rd) begin
						decided_q <= 1'b1;
						verdict_q <= 1'b1;
						st_q      <= last_q ? ST_RD_FINAL : ST_IDLE;
					end else if (!alpha_rd) begin
						decided_q <= 1'b1;
						verdict_q <= 1'b0;
						st_q      <= last_q ? ST_RD_FINAL : ST_IDLE;
					end else begin
						st_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					// read data is registered and comes back in list order
					if (match) begin
						cur_q <= tl_rdata.to_state;
						st_q  <= last_q ? ST_RD_FINAL : ST_IDLE;
					end else if (!rd_v_s1 && (issue_q == n_act)) begin
						decided_q <= 1'b1;
						verdict_q <= 1'b0;
						st_q      <= last_q ? ST_RD_FINAL : ST_IDLE;
					end
				end
				ST_RD_FINAL: begin
					st_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						accepted_q  <= decided_q ? verdict_q : final_rd;
						cur_q       <= start_q;
						decided_q   <= 1'b0;
						verdict_q   <= 1'b0;
						in_string_q <= 1'b0;
						st_q        <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign accepted  = accepted_q;

endmodule

>>> tb/tb.sv
// Self-checking testbench for the DFA string acceptor core.
module tb;

	localparam int DRAIN_CYCLES = 100;
	localparam int STALL_LIMIT  = 3000;
	localparam int WORDS_PER_PHASE = 38;

	// Mirrors the automaton tables and string state; queues the verdict each string must give
	class dfa_verdict_board;
		logic [7:0] tr_from[dsa_pkg::MAX_TRANS_DEF];
		logic [7:0] tr_sym[dsa_pkg::MAX_TRANS_DEF];
		logic [7:0] tr_to[dsa_pkg::MAX_TRANS_DEF];
		bit         final_mark[dsa_pkg::MARK_DEPTH];
		bit         alpha_mark[dsa_pkg::MARK_DEPTH];
		bit   [6:0] trans_count;
		bit   [7:0] start_code;
		bit   [7:0] cur_state;
		bit         decided;
		bit         verdict;
		bit         in_string;
		bit         verdicts_due[$];
		int         errors;

		function new();
			foreach (tr_from[i]) begin
				tr_from[i] = '0;
				tr_sym[i]  = '0;
				tr_to[i]   = '0;
			end
			foreach (final_mark[i]) begin
				final_mark[i] = 1'b0;
				alpha_mark[i] = 1'b0;
			end
			trans_count = '0;
			start_code  = dsa_pkg::RESET_START;
			cur_state   = dsa_pkg::RESET_START;
			decided     = 1'b0;
			verdict     = 1'b0;
			in_string   = 1'b0;
			errors      = 0;
		endfunction

		function void write_reg(logic [dsa_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
			if (idx == dsa_pkg::REG_COUNT)
				trans_count = data[6:0];
			else if (idx == dsa_pkg::REG_START)
				start_code = data;
		endfunction

		// One symbol against the current state: empty list, lambda, alphabet, then first matching entry
		function void advance_on_symbol(logic [7:0] sym);
			int n;
			int i;
			n = (trans_count > dsa_pkg::MAX_TRANS_DEF) ? dsa_pkg::MAX_TRANS_DEF
				: int'(trans_count);
			if (n == 0) begin
				decided = 1'b1;
				verdict = 1'b0;
				return;
			end
			if (sym == dsa_pkg::LAMBDA_SYM && final_mark[cur_state]) begin
				decided = 1'b1;
				verdict = 1'b1;
				return;
			end
			if (!alpha_mark[sym]) begin
				decided = 1'b1;
				verdict = 1'b0;
				return;
			end
			for (i = 0; i < n; i++) begin
				if (tr_sym[i] == sym && tr_from[i] == cur_state) begin
					cur_state = tr_to[i];
					return;
				end
			end
			decided = 1'b1;
			verdict = 1'b0;
		endfunction

		function void take_word(logic [1:0] act, logic [5:0] idx, logic [7:0] fr,
				logic [7:0] sym, logic [7:0] to, logic mk, logic lst);
			case (act)
				dsa_pkg::ACT_TRANS: begin
					tr_from[idx] = fr;
					tr_sym[idx]  = sym;
					tr_to[idx]   = to;
				end
				dsa_pkg::ACT_FINAL: final_mark[sym] = mk;
				dsa_pkg::ACT_ALPHA: alpha_mark[sym] = mk;
				dsa_pkg::ACT_SYMBOL: begin
					if (!in_string) begin
						cur_state = start_code;
						decided   = 1'b0;
						verdict   = 1'b0;
						in_string = 1'b1;
					end
					if (!decided)
						advance_on_symbol(sym);
					if (lst) begin
						if (!decided)
							verdict = final_mark[cur_state];
						verdicts_due.push_back(verdict);
						cur_state = start_code;
						decided   = 1'b0;
						verdict   = 1'b0;
						in_string = 1'b0;
					end
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("tb: mismatch: %s", msg);
			errors++;
		endtask

		task check_verdict(logic got);
			bit want;
			if (verdicts_due.size() == 0) begin
				report($sformatf("verdict %b with no string pending", got));
			end else begin
				want = verdicts_due.pop_front();
				if (got !== want)
					report($sformatf("accepted %b, expected %b", got, want));
			end
		endtask
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [1:0]                    action;
	logic [5:0]                    entry_index;
	logic [7:0]                    from_state;
	logic [7:0]                    symbol;
	logic [7:0]                    to_state;
	logic                          mark_value;
	logic                          last;
	logic                          out_valid;
	logic                          out_stall;
	logic                          accepted;
	logic                          cfg_we;
	logic [dsa_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [7:0]                    cfg_data;

	dfa_verdict_board sb = new();
	bit gaps_on = 1'b1;
	int quiet_cycles = 0;

	dfa_string_acceptor_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.entry_index(entry_index),
		.from_state (from_state),
		.symbol     (symbol),
		.to_state   (to_state),
		.mark_value (mark_value),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.accepted   (accepted),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Result side: random stall before each verdict word while gaps are on
	initial begin
		int n;
		forever begin
			n = gaps_on ? $urandom_range(0, 12) : 0;
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			sb.check_verdict(accepted);
		end
	end

	task automatic put_word(input logic [1:0] act, input logic [5:0] idx, input logic [7:0] fr,
			input logic [7:0] sym, input logic [7:0] to, input logic mk, input logic lst);
		int gap;
		gap = gaps_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		entry_index <= idx;
		from_state  <= fr;
		symbol      <= sym;
		to_state    <= to;
		mark_value  <= mk;
		last        <= lst;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.take_word(act, idx, fr, sym, to, mk, lst);
	endtask

	// String symbol; the fields it does not use carry noise
	task automatic put_symbol(input logic [7:0] sym, input logic lst);
		put_word(dsa_pkg::ACT_SYMBOL, 6'($urandom), 8'($urandom), sym, 8'($urandom),
			1'($urandom), lst);
	endtask

	task automatic put_trans(input logic [5:0] idx, input logic [7:0] fr, input logic [7:0] sym,
			input logic [7:0] to);
		put_word(dsa_pkg::ACT_TRANS, idx, fr, sym, to, 1'($urandom), 1'($urandom));
	endtask

	task automatic put_mark(input logic [1:0] act, input logic [7:0] sym, input logic mk);
		put_word(act, 6'($urandom), 8'($urandom), sym, 8'($urandom), mk, 1'($urandom));
	endtask

	task automatic write_reg(input logic [dsa_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	// Drop valid, let every verdict come back, then cover a symbol still in its scan
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.verdicts_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [7:0] cnt_plan[6];
		logic [7:0] start_plan[6];
		logic [7:0] st[4];
		logic [7:0] sy[3];
		logic [7:0] sym;
		int act_n;
		int base;
		int sent;
		int len;
		int r;

		cnt_plan   = '{8'd64, 8'hFF, 8'd12, 8'd40, 8'd100, 8'd64};
		start_plan = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), dsa_pkg::RESET_START,
			8'($urandom)};

		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		action      <= dsa_pkg::ACT_TRANS;
		entry_index <= '0;
		from_state  <= '0;
		symbol      <= '0;
		to_state    <= '0;
		mark_value  <= 1'b0;
		last        <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= dsa_pkg::REG_COUNT;
		cfg_data    <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list rejects even a lambda
		put_symbol(dsa_pkg::LAMBDA_SYM, 1'b1);
		wait_drained();
		write_reg(dsa_pkg::REG_COUNT, 8'd2);
		put_trans(6'd0, dsa_pkg::RESET_START, 8'hFF, 8'hFF);
		put_trans(6'd1, 8'hFF, 8'h00, dsa_pkg::RESET_START);
		put_mark(dsa_pkg::ACT_FINAL, 8'hFF, 1'b1);
		put_mark(dsa_pkg::ACT_ALPHA, 8'hFF, 1'b1);
		put_mark(dsa_pkg::ACT_ALPHA, 8'h00, 1'b1);
		put_symbol(8'hFF, 1'b1);
		put_symbol(8'hFF, 1'b0);
		put_symbol(8'h00, 1'b1);
		put_symbol(8'hFF, 1'b0);
		put_symbol(dsa_pkg::LAMBDA_SYM, 1'b1);
		put_symbol(dsa_pkg::LAMBDA_SYM, 1'b1);
		put_symbol(8'h00, 1'b1);
		// rejected on the first symbol, the rest is ignored
		put_symbol(8'h61, 1'b0);
		put_symbol(8'hFF, 1'b1);
		put_mark(dsa_pkg::ACT_FINAL, 8'hFF, 1'b0);
		put_symbol(8'hFF, 1'b1);
		// final mark set while the string is open
		put_symbol(8'hFF, 1'b0);
		put_mark(dsa_pkg::ACT_FINAL, 8'hFF, 1'b1);
		put_symbol(dsa_pkg::LAMBDA_SYM, 1'b1);

		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			gaps_on = (ph % 3) != 1;
			st[0] = start_plan[ph];
			for (int s = 1; s < 4; s++)
				st[s] = 8'($urandom);
			for (int y = 0; y < 3; y++)
				sy[y] = 8'($urandom);
			if (ph % 2 == 1)
				sy[2] = dsa_pkg::LAMBDA_SYM;
			write_reg(dsa_pkg::REG_COUNT, cnt_plan[ph]);
			write_reg(dsa_pkg::REG_START, st[0]);
			act_n = (cnt_plan[ph][6:0] > dsa_pkg::MAX_TRANS_DEF) ? dsa_pkg::MAX_TRANS_DEF
				: int'(cnt_plan[ph][6:0]);
			// every slot gets written before any search can reach it
			if (ph == 0) begin
				for (int i = 0; i < dsa_pkg::MAX_TRANS_DEF; i++)
					put_trans(6'(i), 8'($urandom), 8'($urandom), 8'($urandom));
			end
			base = $urandom_range(0, act_n - 12);
			for (int s = 0; s < 4; s++) begin
				for (int y = 0; y < 3; y++) begin
					if ($urandom_range(0, 7) != 0)
						put_trans(6'(base + s * 3 + y), st[s], sy[y], st[$urandom_range(0, 3)]);
					else
						put_trans(6'(base + s * 3 + y), 8'($urandom), 8'($urandom),
							8'($urandom));
				end
			end
			for (int s = 0; s < 4; s++)
				put_mark(dsa_pkg::ACT_FINAL, st[s], 1'($urandom));
			for (int y = 0; y < 3; y++)
				put_mark(dsa_pkg::ACT_ALPHA, sy[y], 1'b1);

			sent = 0;
			while (sent < WORDS_PER_PHASE) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
				for (int j = 0; j < len; j++) begin
					if ($urandom_range(0, 24) == 0)
						put_word(2'($urandom_range(0, 2)), 6'($urandom), 8'($urandom),
							8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
					r = $urandom_range(0, 99);
					if (r < 84)
						sym = sy[$urandom_range(0, 2)];
					else if (r < 92)
						sym = dsa_pkg::LAMBDA_SYM;
					else
						sym = 8'($urandom);
					put_symbol(sym, j == len - 1);
					sent++;
				end
				if ($urandom_range(0, 29) == 0)
					wait_drained();
			end
		end

		wait_drained();
		gaps_on = 1'b1;
		write_reg(dsa_pkg::REG_COUNT, 8'd0);
		for (int k = 0; k < 4; k++) begin
			len = $urandom_range(1, 3);
			for (int j = 0; j < len; j++)
				put_symbol(($urandom_range(0, 1) == 0) ? dsa_pkg::LAMBDA_SYM : 8'($urandom),
					j == len - 1);
		end
		wait_drained();

		if (sb.errors == 0 && sb.verdicts_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
